/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Bodies refer to clk and rst_n of the
// module that uses them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define NRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/nrs_pkg.sv */
// ---------------------------------------------------------------------------
// nrs_pkg
// Shared types and fixed constants of the nearest request scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nrs_pkg;

    // item opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SERVE = 1'b1;

    // fixed widths of the result fields
    localparam int POS_FIELD_W = 16;
    localparam int SUM_W       = 32;

    // control from sequencer to the nearest search unit
    typedef struct packed {
        logic clear;   // start a new search
        logic sample;  // read data is a valid entry, fold it in
    } scan_ctl_t;

    // status of the nearest search unit
    typedef struct packed {
        logic left_found;
        logic right_found;
    } scan_stat_t;

endpackage

`default_nettype wire

/* rtl/nrs_mem.sv */
// ---------------------------------------------------------------------------
// nrs_mem
// Request store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrs_mem #(
    parameter int SLOTS    = 64,
    parameter int POS_BITS = 16,
    parameter int IDX_W    = $clog2(SLOTS)
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_addr,
    input  wire logic [POS_BITS-1:0] wr_data,
    input  wire logic                rd_en,
    input  wire logic [IDX_W-1:0]    rd_addr,
    output logic      [POS_BITS-1:0] rd_data
);

    logic [POS_BITS-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/nrs_scan.sv */
// ---------------------------------------------------------------------------
// nrs_scan
// Nearest search: folds one stored position per cycle into the best
// candidate at or left of the head and the best strictly right of it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrs_scan #(
    parameter int SLOTS    = 64,
    parameter int POS_BITS = 16,
    parameter int IDX_W    = $clog2(SLOTS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire nrs_pkg::scan_ctl_t  ctl,
    input  wire logic [POS_BITS-1:0] head,
    input  wire logic [POS_BITS-1:0] entry_pos,
    input  wire logic [IDX_W-1:0]    entry_idx,
    output nrs_pkg::scan_stat_t      stat,
    output logic      [IDX_W-1:0]    left_idx,
    output logic      [IDX_W-1:0]    right_idx,
    output logic      [POS_BITS-1:0] left_pos,
    output logic      [POS_BITS-1:0] right_pos,
    output logic      [POS_BITS-1:0] left_d,
    output logic      [POS_BITS-1:0] right_d
);

    logic                left_found_reg;
    logic                right_found_reg;
    logic [IDX_W-1:0]    left_idx_reg;
    logic [IDX_W-1:0]    right_idx_reg;
    logic [POS_BITS-1:0] left_pos_reg;
    logic [POS_BITS-1:0] right_pos_reg;
    logic [POS_BITS-1:0] left_d_reg;
    logic [POS_BITS-1:0] right_d_reg;

    logic                is_left;
    logic [POS_BITS-1:0] d;
    logic                take_left;
    logic                take_right;

    always_comb
    begin
        is_left    = (entry_pos <= head);
        d          = is_left ? (head - entry_pos) : (entry_pos - head);
        // strict compare keeps the first hit among equals
        take_left  = ctl.sample && is_left && (!left_found_reg || (d < left_d_reg));
        take_right = ctl.sample && !is_left && (!right_found_reg || (d < right_d_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_found_reg  <= 1'b0;
            right_found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            left_found_reg  <= 1'b0;
            right_found_reg <= 1'b0;
        end
        else
        begin
            if (take_left)
            begin
                left_found_reg <= 1'b1;
            end
            if (take_right)
            begin
                right_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_left)
        begin
            left_idx_reg <= entry_idx;
            left_pos_reg <= entry_pos;
            left_d_reg   <= d;
        end
        if (take_right)
        begin
            right_idx_reg <= entry_idx;
            right_pos_reg <= entry_pos;
            right_d_reg   <= d;
        end
    end

    assign stat.left_found  = left_found_reg;
    assign stat.right_found = right_found_reg;
    assign left_idx         = left_idx_reg;
    assign right_idx        = right_idx_reg;
    assign left_pos         = left_pos_reg;
    assign right_pos        = right_pos_reg;
    assign left_d           = left_d_reg;
    assign right_d          = right_d_reg;

endmodule

`default_nettype wire

/* rtl/nearest_request_scheduler_core.sv */
// ---------------------------------------------------------------------------
// nearest_request_scheduler_core
// Shortest-seek-first scheduler over a store of pending positions.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: op selects
//   add (store position) or serve (move head to nearest pending position).
//   Output channel (out_valid/out_ready) returns exactly one beat per item:
//   served, moved_to, distance, total_travel, dropped.
//   Pending requests live packed in slots 0..count-1 of a single-port-read
//   memory; a serve moves the last entry into the freed slot.
//   Steps from input accept to output beat (receiver ready):
//     add or empty serve: store write (add only), then result
//     serve, N pending:   one memory read per pending entry, then pick,
//                         compaction write-back, result
//   One item in work at a time; the next beat is taken once the result is registered.
//   Reset: store empty, head 0, heading right, travel 0; no clear sweep.
//   Receiver stall: the result holds in the output register and the block
//   stops after finishing the following item until the beat is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_request_scheduler_core #(
    parameter int SLOTS    = 64,
    parameter int POS_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [15:0] position,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             served,
    output logic [15:0]      moved_to,
    output logic [15:0]      distance,
    output logic [31:0]      total_travel,
    output logic             dropped
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int PF_W  = nrs_pkg::POS_FIELD_W;
    localparam int SUM_W = nrs_pkg::SUM_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_PICK = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg,       state_next;
    logic [CNT_W-1:0]    count_reg,       count_next;
    logic [IDX_W-1:0]    data_idx_reg,    data_idx_next;
    logic [IDX_W-1:0]    sel_idx_reg,     sel_idx_next;
    logic [POS_BITS-1:0] head_reg,        head_next;
    logic                heading_r_reg,   heading_r_next;
    logic [SUM_W-1:0]    travel_reg,      travel_next;
    logic                res_served_reg,  res_served_next;
    logic [PF_W-1:0]     res_dist_reg,    res_dist_next;
    logic                res_dropped_reg, res_dropped_next;

    logic                out_valid_reg;
    logic                served_reg;
    logic [PF_W-1:0]     moved_to_reg;
    logic [PF_W-1:0]     distance_reg;
    logic [SUM_W-1:0]    total_reg;
    logic                dropped_reg;

    // memory port
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [POS_BITS-1:0] wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [POS_BITS-1:0] rd_data;

    // search unit
    nrs_pkg::scan_ctl_t  scan_ctl;
    nrs_pkg::scan_stat_t scan_stat;
    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic [POS_BITS-1:0] left_pos;
    logic [POS_BITS-1:0] right_pos;
    logic [POS_BITS-1:0] left_d;
    logic [POS_BITS-1:0] right_d;

    logic                in_fire;
    logic                out_load;
    logic                store_full;
    logic [IDX_W-1:0]    last_idx;
    logic [POS_BITS-1:0] pos_in;
    logic                go_left;
    logic [POS_BITS-1:0] pick_dist;
    logic [POS_BITS-1:0] pick_pos;
    logic [IDX_W-1:0]    pick_idx;
    logic [SUM_W:0]      sum_wide;

    nrs_mem #(
        .SLOTS    (SLOTS),
        .POS_BITS (POS_BITS),
        .IDX_W    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nrs_scan #(
        .SLOTS    (SLOTS),
        .POS_BITS (POS_BITS),
        .IDX_W    (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .head      (head_reg),
        .entry_pos (rd_data),
        .entry_idx (data_idx_reg),
        .stat      (scan_stat),
        .left_idx  (left_idx),
        .right_idx (right_idx),
        .left_pos  (left_pos),
        .right_pos (right_pos),
        .left_d    (left_d),
        .right_d   (right_d)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign store_full = (count_reg == CNT_W'(SLOTS));
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign pos_in     = POS_BITS'(position);

    // Side choice: nearer wins, a tie goes the way the head is heading.
    always_comb
    begin
        go_left   = scan_stat.left_found
                    && (!scan_stat.right_found
                        || (left_d < right_d)
                        || ((left_d == right_d) && !heading_r_reg));
        pick_dist = go_left ? left_d   : right_d;
        pick_pos  = go_left ? left_pos : right_pos;
        pick_idx  = go_left ? left_idx : right_idx;
        sum_wide  = {1'b0, travel_reg} + {1'b0, SUM_W'(pick_dist)};
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        data_idx_next    = data_idx_reg;
        sel_idx_next     = sel_idx_reg;
        head_next        = head_reg;
        heading_r_next   = heading_r_reg;
        travel_next      = travel_reg;
        res_served_next  = res_served_reg;
        res_dist_next    = res_dist_reg;
        res_dropped_next = res_dropped_reg;
        wr_en            = 1'b0;
        wr_addr          = sel_idx_reg;
        wr_data          = rd_data;
        rd_en            = 1'b0;
        rd_addr          = '0;
        scan_ctl         = '0;
        out_load         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_served_next  = 1'b0;
                    res_dist_next    = '0;
                    res_dropped_next = 1'b0;
                    if (op == nrs_pkg::OP_ADD)
                    begin
                        if (store_full)
                        begin
                            res_dropped_next = 1'b1;
                        end
                        else
                        begin
                            // append at the end of the packed region
                            wr_en      = 1'b1;
                            wr_addr    = IDX_W'(count_reg);
                            wr_data    = pos_in;
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = '0;
                        scan_ctl.clear = 1'b1;
                        data_idx_next  = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // rd_data holds entry data_idx_reg; fetch the next one
                scan_ctl.sample = 1'b1;
                if (data_idx_reg == last_idx)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = data_idx_reg + IDX_W'(1);
                    data_idx_next = data_idx_reg + IDX_W'(1);
                end
            end
            S_PICK:
            begin
                head_next = pick_pos;
                if (!go_left)
                begin
                    heading_r_next = 1'b1;
                end
                else if (pick_dist != '0)
                begin
                    heading_r_next = 1'b0;
                end
                travel_next     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                res_served_next = 1'b1;
                res_dist_next   = PF_W'(pick_dist);
                sel_idx_next    = pick_idx;
                // fetch the last entry to fill the hole
                rd_en           = 1'b1;
                rd_addr         = last_idx;
                state_next      = S_MOVE;
            end
            S_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = sel_idx_reg;
                wr_data    = rd_data;
                count_next = count_reg - CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            heading_r_reg <= 1'b1;
            travel_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            heading_r_reg <= heading_r_next;
            travel_reg    <= travel_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg    <= data_idx_next;
        sel_idx_reg     <= sel_idx_next;
        res_served_reg  <= res_served_next;
        res_dist_reg    <= res_dist_next;
        res_dropped_reg <= res_dropped_next;
        if (out_load)
        begin
            served_reg   <= res_served_reg;
            moved_to_reg <= PF_W'(head_reg);
            distance_reg <= res_dist_reg;
            total_reg    <= travel_reg;
            dropped_reg  <= res_dropped_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign served       = served_reg;
    assign moved_to     = moved_to_reg;
    assign distance     = distance_reg;
    assign total_travel = total_reg;
    assign dropped      = dropped_reg;

endmodule

`default_nettype wire

/* rtl/nrs_checker.sv */
// ---------------------------------------------------------------------------
// nrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nrs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        served,
    input wire logic [15:0] moved_to,
    input wire logic [15:0] distance,
    input wire logic [31:0] total_travel,
    input wire logic        dropped
);

    // stalled result beat holds
    `NRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(moved_to) && $stable(total_travel) && $stable(served))

    // one item in work at a time
    `NRS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

    // a beat is never both a serve and a refused add
    `NRS_ASSERT_NOW(a_excl, out_valid, !(served && dropped))

    // no travel without a serve
    `NRS_ASSERT_NOW(a_no_travel, out_valid && !served, distance == 16'd0)

endmodule

bind nearest_request_scheduler_core nrs_checker u_nrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .served       (served),
    .moved_to     (moved_to),
    .distance     (distance),
    .total_travel (total_travel),
    .dropped      (dropped)
);

`default_nettype wire

/* bench/nearest_request_scheduler_core_test.sv */
// ----------------------------------------------------------------------------
// nearest_request_scheduler_core_test
// Self-checking bench for the shortest-seek request scheduler.
// An in-bench model of the pending store, head, heading and travel predicts
// one result beat per input beat; every output beat is checked against the
// oldest prediction. Directed beats hit ties, repeats, requests at the head
// and empty serves; random beats alternate fill and drain runs under several
// idle/stall mixes; a long output hold-off overflows the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_request_scheduler_core_test;

    localparam int          SLOT_COUNT    = 64;
    localparam int          POS_MAX       = 65535;
    localparam logic [31:0] TRAVEL_MAX    = 32'hFFFF_FFFF;
    // run limit for the watchdog
    localparam int          CYCLE_LIMIT   = 1_000_000;
    // settle time after the last result, before the summary
    localparam int          SETTLE_CYCLES = 80;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          HOLDOFF_LEN   = 2000;

    typedef struct packed {
        logic        served;
        logic [15:0] moved_to;
        logic [15:0] distance;
        logic [31:0] total_travel;
        logic        dropped;
    } sched_result_t;

    // ------------------------------------------------------------------------
    // DUT and its ports; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        op        = nrs_pkg::OP_ADD;
    logic [15:0] position  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        served;
    logic [15:0] moved_to;
    logic [15:0] distance;
    logic [31:0] total_travel;
    logic        dropped;

    nearest_request_scheduler_core #(
        .SLOTS    (SLOT_COUNT),
        .POS_BITS (16)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .served       (served),
        .moved_to     (moved_to),
        .distance     (distance),
        .total_travel (total_travel),
        .dropped      (dropped)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scheduler model state (mirror of the block after every accepted beat)
    // ------------------------------------------------------------------------
    logic [15:0] pend_pos  [SLOT_COUNT];
    logic        pend_live [SLOT_COUNT];
    logic [15:0] head_pos;
    logic        head_right;
    logic [31:0] travel;
    int          pend_count;

    // what the run went through, for the closing summary only
    int adds_total;
    int drops_total;
    int serves_total;
    int empty_serves;
    int ties_total;

    // result beats predicted but not yet seen, oldest first
    sched_result_t predicted_beats [$];

    int beats_checked;
    int beat_mismatches;
    int stray_beats;
    int cycle_count;

    // idle mix: sender side is read only by the main sequence, receiver side
    // is written with NBAs so the receiver process sees it race-free
    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_target;
    int holdoff_spent;

    // Apply one item to the model and return the beat it must produce.
    function automatic sched_result_t predict_schedule(logic item_op, logic [15:0] item_pos);
        sched_result_t r;
        int            left_slot;
        int            right_slot;
        logic [15:0]   left_d;
        logic [15:0]   right_d;
        logic [15:0]   d;
        logic [32:0]   sum;
        logic          go_left;
        r              = '0;
        r.moved_to     = head_pos;
        r.total_travel = travel;
        if (item_op == nrs_pkg::OP_ADD)
        begin
            adds_total++;
            r.dropped = 1'b1;
            // lowest free slot takes the request
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (!pend_live[i])
                begin
                    pend_live[i] = 1'b1;
                    pend_pos[i]  = item_pos;
                    pend_count++;
                    r.dropped    = 1'b0;
                    break;
                end
            end
            if (r.dropped)
                drops_total++;
            return r;
        end

        serves_total++;
        left_slot  = -1;
        right_slot = -1;
        left_d     = '0;
        right_d    = '0;
        // left side includes the head itself; first hit wins among equals
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (pend_live[i])
            begin
                if (pend_pos[i] <= head_pos)
                begin
                    d = head_pos - pend_pos[i];
                    if (left_slot < 0 || d < left_d)
                    begin
                        left_slot = i;
                        left_d    = d;
                    end
                end
                else
                begin
                    d = pend_pos[i] - head_pos;
                    if (right_slot < 0 || d < right_d)
                    begin
                        right_slot = i;
                        right_d    = d;
                    end
                end
            end
        end

        if (left_slot < 0 && right_slot < 0)
        begin
            empty_serves++;
            return r;
        end

        if (left_slot < 0)
            go_left = 1'b0;
        else if (right_slot < 0)
            go_left = 1'b1;
        else if (left_d != right_d)
            go_left = (left_d < right_d);
        else
        begin
            // equal pull from both sides: keep going the current way
            go_left = !head_right;
            ties_total++;
        end

        if (go_left)
        begin
            d = left_d;
            if (d != 0)
                head_right = 1'b0;   // zero-distance serve keeps the heading
            head_pos = pend_pos[left_slot];
            pend_live[left_slot] = 1'b0;
        end
        else
        begin
            d          = right_d;
            head_right = 1'b1;
            head_pos   = pend_pos[right_slot];
            pend_live[right_slot] = 1'b0;
        end
        pend_count--;

        // travel saturates instead of wrapping
        sum = {1'b0, travel} + 33'(d);
        travel = sum[32] ? TRAVEL_MAX : sum[31:0];

        r.served       = 1'b1;
        r.moved_to     = head_pos;
        r.distance     = d;
        r.total_travel = travel;
        return r;
    endfunction

    // Add positions: full range and clustered around the head in equal share,
    // the latter to provoke ties and zero-distance serves, plus the two ends and repeats.
    function automatic logic [15:0] pick_position();
        int near;
        int live_slots [$];
        case ($urandom_range(9))
            0, 1, 2, 3:
                return 16'($urandom);
            4, 5, 6, 7:
            begin
                near = int'(head_pos) + int'($urandom_range(16)) - 8;
                if (near < 0)
                    near = 0;
                if (near > POS_MAX)
                    near = POS_MAX;
                return 16'(near);
            end
            8:
                return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default:
            begin
                foreach (pend_live[i])
                    if (pend_live[i])
                        live_slots.push_back(i);
                if (live_slots.size() == 0)
                    return 16'($urandom);
                return pend_pos[live_slots[$urandom_range(live_slots.size() - 1)]];
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one beat per call. Valid stays high on return so a
    // back-to-back beat never lowers and raises it in the same step.
    // ------------------------------------------------------------------------
    task automatic send_item(logic item_op, logic [15:0] item_pos);
        if (send_idle_pct != 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        op       <= item_op;
        position <= item_pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_beats.push_back(predict_schedule(item_op, item_pos));
    endtask

    // Drop valid and wait until every predicted beat has come back.
    // Polled on the falling edge so the checker's pop is already done.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (predicted_beats.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus a counted hold-off stretch
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (holdoff_spent < holdoff_target)
            begin
                out_ready <= 1'b0;
                holdoff_spent++;
            end
            else
                out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: each accepted beat against the oldest prediction.
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {served, moved_to, distance, total_travel, dropped};
            if (predicted_beats.size() == 0)
            begin
                stray_beats++;
                if (stray_beats + beat_mismatches <= REPORT_LIMIT)
                    $display("[%0t] beat with nothing predicted: served=%0b moved_to=%0d",
                             $realtime, got.served, got.moved_to);
            end
            else
            begin
                want = predicted_beats.pop_front();
                beats_checked++;
                if (got.served !== want.served || got.moved_to !== want.moved_to
                    || got.distance !== want.distance
                    || got.total_travel !== want.total_travel
                    || got.dropped !== want.dropped)
                begin
                    beat_mismatches++;
                    if (stray_beats + beat_mismatches <= REPORT_LIMIT)
                    begin
                        $display("[%0t] beat %0d mismatch", $realtime, beats_checked);
                        $display("  exp served=%0b moved_to=%0d distance=%0d travel=%0d dropped=%0b",
                                 want.served, want.moved_to, want.distance,
                                 want.total_travel, want.dropped);
                        $display("  got served=%0b moved_to=%0d distance=%0d travel=%0d dropped=%0b",
                                 got.served, got.moved_to, got.distance,
                                 got.total_travel, got.dropped);
                    end
                end
            end
        end
    end

    // Run limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d beats still outstanding",
                 cycle_count, predicted_beats.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked walk: empty serve, request at the head, tie broken both
    // ways, repeated positions, both ends of the position range.
    task automatic test_directed();
        send_item(nrs_pkg::OP_SERVE, 16'h0000);   // nothing pending
        send_item(nrs_pkg::OP_ADD,   16'h0000);   // at the head
        send_item(nrs_pkg::OP_SERVE, 16'hFFFF);   // distance 0, heading stays right
        send_item(nrs_pkg::OP_ADD,   16'd100);
        send_item(nrs_pkg::OP_ADD,   16'hFFFF);
        send_item(nrs_pkg::OP_SERVE, 16'h5555);   // -> 100
        send_item(nrs_pkg::OP_ADD,   16'd50);
        send_item(nrs_pkg::OP_ADD,   16'd150);
        send_item(nrs_pkg::OP_SERVE, 16'hAAAA);   // 50 vs 150 tie, heading right -> 150
        send_item(nrs_pkg::OP_ADD,   16'd100);
        send_item(nrs_pkg::OP_SERVE, 16'h0000);   // -> 100, now heading left
        send_item(nrs_pkg::OP_ADD,   16'd150);
        send_item(nrs_pkg::OP_SERVE, 16'h0001);   // tie again, heading left -> 50
        send_item(nrs_pkg::OP_ADD,   16'd50);
        send_item(nrs_pkg::OP_ADD,   16'd50);
        send_item(nrs_pkg::OP_SERVE, 16'h8000);   // repeat at head, distance 0
        send_item(nrs_pkg::OP_SERVE, 16'h7FFF);   // second repeat, heading still left
        send_item(nrs_pkg::OP_SERVE, 16'h0000);   // only right side left -> 150
        send_item(nrs_pkg::OP_SERVE, 16'h0000);   // -> 65535
        send_item(nrs_pkg::OP_SERVE, 16'h0000);   // empty again
        send_item(nrs_pkg::OP_ADD,   16'h0000);
        send_item(nrs_pkg::OP_SERVE, 16'hFFFF);   // full-range sweep left
        send_item(nrs_pkg::OP_ADD,   16'h5555);
        send_item(nrs_pkg::OP_ADD,   16'hAAAA);
        send_item(nrs_pkg::OP_SERVE, 16'h1234);
        send_item(nrs_pkg::OP_SERVE, 16'hEDCB);
    endtask

    // Fill-heavy and drain-heavy runs of random length, so the store swings
    // between empty and full, under each idle/stall mix in turn.
    task automatic test_random_phases(int items_per_phase);
        int   idle_table  [4] = '{0, 50, 0, 8};
        int   stall_table [4] = '{0, 0, 50, 8};
        int   run_left;
        logic fill_mode;
        logic item_op;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  =  idle_table[ph];
            recv_stall_pct <= stall_table[ph];
            run_left = 0;
            for (int n = 0; n < items_per_phase; n++)
            begin
                if (run_left == 0)
                begin
                    fill_mode = $urandom_range(1);
                    run_left  = $urandom_range(150, 20);
                end
                run_left--;
                item_op = ($urandom_range(99) < (fill_mode ? 85 : 25))
                          ? nrs_pkg::OP_ADD : nrs_pkg::OP_SERVE;
                send_item(item_op,
                          (item_op == nrs_pkg::OP_ADD) ? pick_position() : 16'($urandom));
            end
        end
    endtask

    // Long receiver hold-off while adds keep coming: the block backs up and
    // stalls its input; the burst overflows an empty store by 16 beats.
    // Then the sender waits for every beat before draining the store.
    task automatic test_backpressure();
        send_idle_pct  =  0;
        recv_stall_pct <= 0;
        while (pend_count != 0)
            send_item(nrs_pkg::OP_SERVE, 16'($urandom));
        holdoff_target <= holdoff_target + HOLDOFF_LEN;
        for (int n = 0; n < SLOT_COUNT + 16; n++)
            send_item(nrs_pkg::OP_ADD, pick_position());
        wait_all_results();
        for (int n = 0; n < SLOT_COUNT + 4; n++)
            send_item(nrs_pkg::OP_SERVE, 16'($urandom));
        wait_all_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        foreach (pend_live[i])
        begin
            pend_live[i] = 1'b0;
            pend_pos[i]  = '0;
        end
        head_pos       = '0;
        head_right     = 1'b1;
        travel         = '0;
        pend_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_target = 0;
        holdoff_spent  = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases(250);
        test_backpressure();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d adds (%0d refused, store full) and %0d serves",
                 adds_total, drops_total, serves_total);
        $display("(%0d on an empty store, %0d heading-decided ties); %0d beats checked, travel %0d",
                 empty_serves, ties_total, beats_checked, travel);
        if (beat_mismatches == 0 && stray_beats == 0 && predicted_beats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
